FILE: rtl/core/csdc_pkg.sv
// Package of the clock set and display controller: item and result types, mode codes,
// register indexes, reset values and the seven-segment font.
// Depends on nothing; csdc_press, csdc_display and the top level import it.
package csdc_pkg;

	localparam int unsigned CFG_W     = 16;
	localparam int unsigned CFG_IDX_W = 2;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_SHORT_MIN = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SHORT_MAX = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LONG      = 2'd2;

	localparam logic [CFG_W-1:0] SHORT_MIN_RST = 16'd50;
	localparam logic [CFG_W-1:0] SHORT_MAX_RST = 16'd1500;
	localparam logic [CFG_W-1:0] LONG_RST      = 16'd2000;

	localparam logic [4:0] EDIT_HOURS_RST = 5'd12;
	localparam logic [5:0] EDIT_MINS_RST  = 6'd0;

	localparam logic [5:0] HOURS_PER_DAY    = 6'd24;
	localparam logic [6:0] MINUTES_PER_HOUR = 7'd60;

	localparam logic [7:0] COLON_BIT = 8'h80;

	// floor(x / 125) for x below 2^31 is (x * BLINK_RECIP) >> BLINK_SHIFT.
	// With x = now_ms >> 1 this gives now_ms / 250.
	localparam logic [31:0] BLINK_RECIP = 32'd2199023256;
	localparam int unsigned BLINK_SHIFT = 38;

	typedef enum logic [1:0] {
		UI_RUN       = 2'd0,
		UI_EDIT_HRS  = 2'd1,
		UI_EDIT_MINS = 2'd2
	} mode_t;

	typedef struct packed {
		logic        command;
		logic [31:0] now_ms;
		logic        button_pressed;
		logic [4:0]  clock_hours;
		logic [5:0]  clock_minutes;
	} item_t;

	typedef struct packed {
		logic       digit_valid;
		logic [1:0] digit_index;
		logic [7:0] segment_byte;
		logic       clock_write;
		logic [4:0] write_hours;
		logic [5:0] write_minutes;
		logic [1:0] mode;
	} result_t;

	// Outcome of one event on the press timer and the edit state
	typedef struct packed {
		mode_t      mode;
		logic [4:0] edit_hours;
		logic [5:0] edit_minutes;
		logic       clock_write;
		logic [4:0] write_hours;
		logic [5:0] write_minutes;
	} press_out_t;

	typedef logic [7:0] seg_t;

	function automatic seg_t seg_font(input logic [3:0] d);
		seg_t g;
		case (d)
			4'd0: g = 8'h3F;
			4'd1: g = 8'h06;
			4'd2: g = 8'h5B;
			4'd3: g = 8'h4F;
			4'd4: g = 8'h66;
			4'd5: g = 8'h6D;
			4'd6: g = 8'h7D;
			4'd7: g = 8'h07;
			4'd8: g = 8'h7F;
			4'd9: g = 8'h6F;
			default: g = 8'h00;
		endcase
		return g;
	endfunction

	// Tens glyph in the upper byte, units glyph in the lower byte, for values up to 63.
	function automatic logic [15:0] glyph_pair(input logic [5:0] v);
		logic [3:0] tens;
		logic [5:0] units;
		tens = 4'd0;
		for (int i = 1; i <= 6; i++) begin
			if (v >= 6'(i * 10))
				tens = 4'(i);
		end
		units = v - 6'(tens) * 6'd10;
		return {seg_font(tens), seg_font(units[3:0])};
	endfunction

endpackage

FILE: rtl/core/csdc_chan_if.sv
// Valid/ready channel carrying one payload of type T per transfer.
// Used with the item and result types of csdc_pkg.
interface csdc_chan_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/core/csdc_press.sv
// Button press timer with mode sequencing and edit-time registers.
// Depends on csdc_pkg.
module csdc_press (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          step,
	input  logic [31:0]                   now_ms,
	input  logic                          button_pressed,
	input  logic [4:0]                    clock_hours,
	input  logic [5:0]                    clock_minutes,
	input  logic [csdc_pkg::CFG_W-1:0]    short_min,
	input  logic [csdc_pkg::CFG_W-1:0]    short_max,
	input  logic [csdc_pkg::CFG_W-1:0]    long_ms,
	output csdc_pkg::press_out_t          nxt
);
	import csdc_pkg::*;

	mode_t       mode_q;
	logic [4:0]  edit_hours_q;
	logic [5:0]  edit_minutes_q;
	logic [31:0] press_start_q;
	logic        press_active_q;

	logic [31:0] held;
	logic        start_press;
	logic        active_nxt;
	logic [5:0]  hours_inc;
	logic [6:0]  mins_inc;
	logic [4:0]  hours_wrap;
	logic [5:0]  mins_wrap;

	assign held      = now_ms - press_start_q;
	assign hours_inc = {1'b0, edit_hours_q} + 6'd1;
	assign mins_inc  = {1'b0, edit_minutes_q} + 7'd1;
	assign hours_wrap = (hours_inc >= HOURS_PER_DAY) ? 5'(hours_inc - HOURS_PER_DAY)
	                                                 : hours_inc[4:0];
	assign mins_wrap  = (mins_inc >= MINUTES_PER_HOUR) ? 6'(mins_inc - MINUTES_PER_HOUR)
	                                                   : mins_inc[5:0];

	always_comb begin
		nxt          = '{mode: mode_q, edit_hours: edit_hours_q, edit_minutes: edit_minutes_q,
		                 clock_write: 1'b0, write_hours: 5'd0, write_minutes: 6'd0};
		start_press  = 1'b0;
		active_nxt   = press_active_q;
		if (button_pressed && !press_active_q) begin
			start_press = 1'b1;
			active_nxt  = 1'b1;
		end else if (!button_pressed && press_active_q) begin
			active_nxt = 1'b0;
			if (held >= {16'd0, short_min} && held < {16'd0, short_max}) begin
				case (mode_q)
					UI_EDIT_HRS:  nxt.edit_hours   = hours_wrap;
					UI_EDIT_MINS: nxt.edit_minutes = mins_wrap;
					default: ;
				endcase
			end
		end else if (button_pressed && press_active_q && held >= {16'd0, long_ms}) begin
			active_nxt = 1'b0;
			case (mode_q)
				UI_EDIT_HRS: nxt.mode = UI_EDIT_MINS;
				UI_EDIT_MINS: begin
					nxt.mode          = UI_RUN;
					nxt.clock_write   = 1'b1;
					nxt.write_hours   = edit_hours_q;
					nxt.write_minutes = edit_minutes_q;
				end
				default: begin
					nxt.mode         = UI_EDIT_HRS;
					nxt.edit_hours   = clock_hours;
					nxt.edit_minutes = clock_minutes;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q         <= UI_RUN;
			edit_hours_q   <= EDIT_HOURS_RST;
			edit_minutes_q <= EDIT_MINS_RST;
			press_start_q  <= 32'd0;
			press_active_q <= 1'b0;
		end else if (step) begin
			mode_q         <= nxt.mode;
			edit_hours_q   <= nxt.edit_hours;
			edit_minutes_q <= nxt.edit_minutes;
			press_active_q <= active_nxt;
			if (start_press)
				press_start_q <= now_ms;
		end
	end

endmodule

FILE: rtl/core/csdc_display.sv
// Builds the four seven-segment digit bytes from the mode, the time shown and the colon.
// Depends on csdc_pkg.
module csdc_display (
	input  csdc_pkg::mode_t   mode,
	input  logic [4:0]        edit_hours,
	input  logic [5:0]        edit_minutes,
	input  logic [4:0]        clock_hours,
	input  logic [5:0]        clock_minutes,
	input  logic              colon_on,
	input  logic              blink_off,
	output csdc_pkg::seg_t    digits [4]
);
	import csdc_pkg::*;

	logic [15:0] hours_g;
	logic [15:0] mins_g;
	logic        setting;
	logic        hours_on;
	logic        mins_on;
	seg_t        colon;

	assign setting = (mode == UI_EDIT_HRS) || (mode == UI_EDIT_MINS);
	assign hours_g = glyph_pair(setting ? {1'b0, edit_hours} : {1'b0, clock_hours});
	assign mins_g  = glyph_pair(setting ? edit_minutes : clock_minutes);

	// The pair under edit is blanked during the odd 250 ms slots.
	assign hours_on = !setting || (mode == UI_EDIT_MINS) || !blink_off;
	assign mins_on  = !setting || (mode == UI_EDIT_HRS) || !blink_off;
	assign colon    = (setting || colon_on) ? COLON_BIT : 8'h00;

	assign digits[3] = (hours_on ? hours_g[15:8] : 8'h00) | colon;
	assign digits[2] = (hours_on ? hours_g[7:0]  : 8'h00) | colon;
	assign digits[1] = (mins_on  ? mins_g[15:8]  : 8'h00) | colon;
	assign digits[0] = (mins_on  ? mins_g[7:0]   : 8'h00) | colon;

endmodule

FILE: rtl/core/clock_set_and_display_controller_unit.sv
// Top level of the clock set and display controller: input register, event logic, result register.
// Depends on csdc_pkg, csdc_chan_if, csdc_press and csdc_display.
//
//   Channel   Direction  Payload      Handshake
//   item      in         item_t       valid/ready, transfer when both high
//   result    out        result_t     valid/ready, transfer when both high
//   cfg       in         16-bit data  cfg_we, cfg_index, cfg_data, no wait
//
// The block sustains one item per clock cycle while its results are taken. An item is held in
// the input register, and its result is loaded into the result register as the item leaves it.
// All state is updated in the single cycle in which an item leaves the input register. Reset
// clears every control and state register to its documented value; no clearing pass is needed.
// When the result is not taken the input register still absorbs one more item, after which
// item.ready falls until result moves on.
module clock_set_and_display_controller_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	csdc_chan_if.sink                           item,
	csdc_chan_if.source                         result,
	input  logic                                cfg_we,
	input  logic [csdc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [csdc_pkg::CFG_W-1:0]          cfg_data
);
	import csdc_pkg::*;

	// Configuration registers, for the user to write only while the block is idle; not enforced here.
	logic [CFG_W-1:0] short_min_q;
	logic [CFG_W-1:0] short_max_q;
	logic [CFG_W-1:0] long_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			short_min_q <= SHORT_MIN_RST;
			short_max_q <= SHORT_MAX_RST;
			long_q      <= LONG_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SHORT_MIN: short_min_q <= cfg_data;
				CFG_SHORT_MAX: short_max_q <= cfg_data;
				CFG_LONG:      long_q      <= cfg_data;
				default: ;
			endcase
		end
	end

	// Input register. The blink phase, bit 0 of now_ms / 250, is worked out by a
	// reciprocal multiplication on the way in so that it does not share a cycle with
	// the event logic.
	item_t       item_s1;
	logic        blink_s1;
	logic        valid_s1;
	logic        advance;
	logic        take;
	logic [62:0] blink_prod;

	assign blink_prod = {32'd0, item.data.now_ms[31:1]} * {31'd0, BLINK_RECIP};

	assign advance    = valid_s1 && (!result.valid || result.ready);
	assign item.ready = !valid_s1 || advance;
	assign take       = item.valid && item.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (take)
			valid_s1 <= 1'b1;
		else if (advance)
			valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1  <= item.data;
			blink_s1 <= blink_prod[BLINK_SHIFT];
		end
	end

	// Event logic: scan digit, colon, press timer and display rebuild.
	logic       colon_q;
	logic [1:0] scan_q;
	seg_t       digit_seg_q [4];
	logic       colon_nxt;
	press_out_t press_nxt;
	seg_t       digits_nxt [4];
	result_t    res_nxt;
	result_t    result_q;
	logic       result_valid_q;

	// An alarm toggles the colon before the display is rebuilt.
	assign colon_nxt = colon_q ^ item_s1.command;

	csdc_press u_press (
		.clk            (clk),
		.arst_n         (arst_n),
		.step           (advance),
		.now_ms         (item_s1.now_ms),
		.button_pressed (item_s1.button_pressed),
		.clock_hours    (item_s1.clock_hours),
		.clock_minutes  (item_s1.clock_minutes),
		.short_min      (short_min_q),
		.short_max      (short_max_q),
		.long_ms        (long_q),
		.nxt            (press_nxt)
	);

	csdc_display u_display (
		.mode          (press_nxt.mode),
		.edit_hours    (press_nxt.edit_hours),
		.edit_minutes  (press_nxt.edit_minutes),
		.clock_hours   (item_s1.clock_hours),
		.clock_minutes (item_s1.clock_minutes),
		.colon_on      (colon_nxt),
		.blink_off     (blink_s1),
		.digits        (digits_nxt)
	);

	// A tick shows the byte stored before this event's rebuild.
	always_comb begin
		res_nxt.digit_valid   = !item_s1.command;
		res_nxt.digit_index   = item_s1.command ? 2'd0 : scan_q;
		res_nxt.segment_byte  = item_s1.command ? 8'h00 : digit_seg_q[scan_q];
		res_nxt.clock_write   = press_nxt.clock_write;
		res_nxt.write_hours   = press_nxt.write_hours;
		res_nxt.write_minutes = press_nxt.write_minutes;
		res_nxt.mode          = press_nxt.mode;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			colon_q <= 1'b0;
			scan_q  <= 2'd0;
			for (int i = 0; i < 4; i++)
				digit_seg_q[i] <= 8'h00;
		end else if (advance) begin
			colon_q <= colon_nxt;
			if (!item_s1.command)
				scan_q <= scan_q + 2'd1;
			for (int i = 0; i < 4; i++)
				digit_seg_q[i] <= digits_nxt[i];
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			result_valid_q <= 1'b0;
		else if (advance)
			result_valid_q <= 1'b1;
		else if (result.ready)
			result_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (advance)
			result_q <= res_nxt;
	end

	assign result.valid = result_valid_q;
	assign result.data  = result_q;

	// A clock write only ever accompanies the return to normal mode.
	a_write_in_normal: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.data.clock_write |-> result.data.mode == UI_RUN)
		else $error("clock write outside normal mode");

	// An alarm result carries no digit.
	a_no_digit_on_alarm: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.data.digit_valid
		|-> result.data.digit_index == 2'd0 && result.data.segment_byte == 8'h00)
		else $error("digit fields set without a digit");

	// The write fields are zero unless a write is signalled.
	a_write_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.data.clock_write
		|-> result.data.write_hours == 5'd0 && result.data.write_minutes == 6'd0)
		else $error("write fields set without a clock write");

	// Input is refused only while both registers hold an item and the result is stalled.
	a_ready_only_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!item.ready |-> valid_s1 && result.valid && !result.ready)
		else $error("item refused without a stall");

	// A stalled result keeps the input register from moving.
	a_stall_holds_s1: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && result.valid && !result.ready |=> valid_s1)
		else $error("input register lost an item during a stall");

endmodule
